// ===== rtl/fpp_pkg.sv =====
// Shared types, constants and the CRC-16/Modbus byte update for the frame parser.
// Depends on nothing; every other file of the block but fpp_ram imports it.
`default_nettype none

package fpp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int CFG_IDX_W   = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] HDR_FIRST_RST = 8'hAA;
    localparam logic [7:0] HDR_SECOND_RST = 8'h55;
    localparam logic [7:0] EXP_VERSION_RST = 8'h01;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 2'd2;

    typedef enum logic [3:0] {
        ST_HEAD0,
        ST_HEAD1,
        ST_VER,
        ST_TYPE,
        ST_SEQL,
        ST_SEQH,
        ST_LENL,
        ST_LENH,
        ST_PAY,
        ST_CRCL,
        ST_CRCH,
        ST_EMIT_EMPTY,
        ST_EMIT_RD,
        ST_EMIT_LD
    } phase_t;

    typedef struct packed {
        logic ld_ver;
        logic ld_type;
        logic ld_seql;
        logic ld_seqh;
        logic ld_lenl;
        logic ld_lenh;
        logic ld_crcl;
        logic crc_init;
        logic crc_upd;
        logic pay_wr;
        logic cnt_clr;
        logic cnt_inc;
        logic emit_rd;
        logic emit_ld;
        logic emit_empty;
    } cmd_t;

    typedef struct packed {
        logic hdr_first_hit;
        logic hdr_second_hit;
        logic ver_ok;
        logic len_ok;
        logic len_zero_in;
        logic len_zero_held;
        logic cnt_last;
        logic crc_ok;
        logic out_free;
    } sts_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/framed_packet_parser_crc16_unit.sv =====
// Top level of the framed packet parser with CRC-16/Modbus check.
// Depends on fpp_pkg, fpp_ctrl, fpp_datapath and fpp_ram.
//
// The s_ channel carries one received byte per request. The parser hunts for the
// two configured header bytes, then takes version, type, sequence, length, payload
// and CRC, one byte per cycle; each byte but the header and CRC gets a CRC byte update.
// While a frame is parsed s_ready stays high, so bytes are taken back to back.
// After a good CRC the block emits one m_ request per payload byte, or a single
// request with m_data_valid low for an empty frame, with m_last on the final one.
// Emission reads the payload RAM, whose read is registered, so each result
// takes an EMIT_RD state and then an EMIT_LD state, one byte at a time; s_ready
// is low during emission, and an empty frame takes only the EMIT_EMPTY state.
// Results sit in an output register; a stalled receiver holds the emission,
// and the last result of a frame can wait there while new bytes are taken.
// Frames with a bad version, oversize length or wrong CRC give no result.
// The cfg_ channel writes header_first (0), header_second (1) and expected_version (2),
// is always ready, and must be used only while idle: the block does not enforce it.
// Reset (aresetn low, synchronous) returns to header hunting and restores
// the configuration defaults 0xAA, 0x55 and 1.
`default_nettype none

module framed_packet_parser_crc16_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_rx_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_frame_version,
    output logic [7:0]                         m_frame_type,
    output logic [15:0]                        m_frame_sequence,
    output logic [6:0]                         m_frame_length,
    output logic [7:0]                         m_data_byte,
    output logic                               m_data_valid,
    output logic                               m_last
);

    import fpp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    fpp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fpp_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_rx_byte        (s_rx_byte),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_version  (m_frame_version),
        .m_frame_type     (m_frame_type),
        .m_frame_sequence (m_frame_sequence),
        .m_frame_length   (m_frame_length),
        .m_data_byte      (m_data_byte),
        .m_data_valid     (m_data_valid),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire

// ===== rtl/fpp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module fpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fpp_ctrl.sv =====
// Parser state machine: sequences header, fields, payload, CRC and result emission.
// Depends on fpp_pkg for the phase type and the command and status structs.
`default_nettype none

module fpp_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire fpp_pkg::sts_t sts,
    output fpp_pkg::cmd_t     cmd
);

    import fpp_pkg::*;

    phase_t state_reg;
    phase_t state_next;
    logic   acc;

    always_comb begin
        unique case (state_reg)
            ST_HEAD0, ST_HEAD1, ST_VER, ST_TYPE, ST_SEQL, ST_SEQH,
            ST_LENL, ST_LENH, ST_PAY, ST_CRCL, ST_CRCH: s_ready = 1'b1;
            default: s_ready = 1'b0;
        endcase
    end

    assign acc = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HEAD0;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_HEAD0: if (acc && sts.hdr_first_hit) state_next = ST_HEAD1;
            ST_HEAD1: if (acc) state_next = sts.hdr_second_hit ? ST_VER : ST_HEAD0;
            ST_VER:   if (acc) state_next = ST_TYPE;
            ST_TYPE:  if (acc) state_next = ST_SEQL;
            ST_SEQL:  if (acc) state_next = ST_SEQH;
            ST_SEQH:  if (acc) state_next = ST_LENL;
            ST_LENL:  if (acc) state_next = ST_LENH;
            ST_LENH: begin
                if (acc) begin
                    if (!sts.ver_ok || !sts.len_ok) state_next = ST_HEAD0;
                    else if (sts.len_zero_in)       state_next = ST_CRCL;
                    else                            state_next = ST_PAY;
                end
            end
            ST_PAY:   if (acc && sts.cnt_last) state_next = ST_CRCL;
            ST_CRCL:  if (acc) state_next = ST_CRCH;
            ST_CRCH: begin
                if (acc) begin
                    if (!sts.crc_ok)            state_next = ST_HEAD0;
                    else if (sts.len_zero_held) state_next = ST_EMIT_EMPTY;
                    else                        state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_EMPTY: if (sts.out_free) state_next = ST_HEAD0;
            ST_EMIT_RD:    state_next = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (sts.out_free) state_next = sts.cnt_last ? ST_HEAD0 : ST_EMIT_RD;
            end
            default: state_next = ST_HEAD0;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_HEAD1: cmd.crc_init = acc && sts.hdr_second_hit;
            ST_VER: begin
                cmd.ld_ver  = acc;
                cmd.crc_upd = acc;
            end
            ST_TYPE: begin
                cmd.ld_type = acc;
                cmd.crc_upd = acc;
            end
            ST_SEQL: begin
                cmd.ld_seql = acc;
                cmd.crc_upd = acc;
            end
            ST_SEQH: begin
                cmd.ld_seqh = acc;
                cmd.crc_upd = acc;
            end
            ST_LENL: begin
                cmd.ld_lenl = acc;
                cmd.crc_upd = acc;
            end
            ST_LENH: begin
                cmd.ld_lenh = acc;
                cmd.crc_upd = acc;
                cmd.cnt_clr = acc;
            end
            ST_PAY: begin
                cmd.pay_wr  = acc;
                cmd.crc_upd = acc;
                cmd.cnt_inc = acc;
            end
            ST_CRCL: cmd.ld_crcl = acc;
            ST_CRCH: cmd.cnt_clr = acc;
            ST_EMIT_EMPTY: cmd.emit_empty = sts.out_free;
            ST_EMIT_RD: cmd.emit_rd = 1'b1;
            ST_EMIT_LD: begin
                cmd.emit_ld = sts.out_free;
                cmd.cnt_inc = sts.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/fpp_datapath.sv =====
// Datapath: configuration registers, header holds, CRC, payload RAM and output register.
// Depends on fpp_pkg and instantiates fpp_ram for the payload store.
`default_nettype none

module fpp_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic [fpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic [7:0]                    s_rx_byte,
    input  wire fpp_pkg::cmd_t                 cmd,
    output fpp_pkg::sts_t                      sts,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_frame_version,
    output logic [7:0]                         m_frame_type,
    output logic [15:0]                        m_frame_sequence,
    output logic [6:0]                         m_frame_length,
    output logic [7:0]                         m_data_byte,
    output logic                               m_data_valid,
    output logic                               m_last
);

    import fpp_pkg::*;

    logic [7:0]       hdr_first_reg;
    logic [7:0]       hdr_second_reg;
    logic [7:0]       exp_version_reg;
    logic [7:0]       version_reg;
    logic [7:0]       type_reg;
    logic [15:0]      seq_reg;
    logic [7:0]       len_lo_reg;
    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [7:0]       crc_lo_reg;
    logic [15:0]      crc_reg;
    logic [7:0]       ram_rd_data;
    logic             m_valid_reg;
    logic             out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_first_reg   <= HDR_FIRST_RST;
            hdr_second_reg  <= HDR_SECOND_RST;
            exp_version_reg <= EXP_VERSION_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_HEADER_FIRST:     hdr_first_reg   <= cfg_data;
                REG_HEADER_SECOND:    hdr_second_reg  <= cfg_data;
                REG_EXPECTED_VERSION: exp_version_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_ver)  version_reg      <= s_rx_byte;
        if (cmd.ld_type) type_reg         <= s_rx_byte;
        if (cmd.ld_seql) seq_reg[7:0]     <= s_rx_byte;
        if (cmd.ld_seqh) seq_reg[15:8]    <= s_rx_byte;
        if (cmd.ld_lenl) len_lo_reg       <= s_rx_byte;
        if (cmd.ld_lenh) len_reg          <= len_lo_reg[CNT_W-1:0];
        if (cmd.ld_crcl) crc_lo_reg       <= s_rx_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else if (cmd.crc_init) begin
            crc_reg <= CRC_INIT;
        end else if (cmd.crc_upd) begin
            crc_reg <= crc16_byte(crc_reg, s_rx_byte);
        end
    end

    assign cnt_next = cnt_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_next;
        end
    end

    fpp_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (cmd.pay_wr),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (s_rx_byte),
        .rd_en   (cmd.emit_rd),
        .rd_addr (cnt_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign sts.hdr_first_hit  = (s_rx_byte == hdr_first_reg);
    assign sts.hdr_second_hit = (s_rx_byte == hdr_second_reg);
    assign sts.ver_ok         = (version_reg == exp_version_reg);
    assign sts.len_ok         = (s_rx_byte == 8'h00) && (len_lo_reg <= 8'(MAX_PAYLOAD));
    assign sts.len_zero_in    = (s_rx_byte == 8'h00) && (len_lo_reg == 8'h00);
    assign sts.len_zero_held  = (len_reg == '0);
    assign sts.cnt_last       = (cnt_next == (cmd.pay_wr ? len_lo_reg[CNT_W-1:0] : len_reg));
    assign sts.crc_ok         = ({s_rx_byte, crc_lo_reg} == crc_reg);
    assign sts.out_free       = !m_valid_reg || m_ready;

    assign out_load = cmd.emit_ld || cmd.emit_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_frame_version  <= version_reg;
            m_frame_type     <= type_reg;
            m_frame_sequence <= seq_reg;
            m_frame_length   <= len_reg;
            m_data_byte      <= cmd.emit_ld ? ram_rd_data : 8'h00;
            m_data_valid     <= cmd.emit_ld;
            m_last           <= cmd.emit_empty || sts.cnt_last;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== tb/fpp_frame_checker.sv =====
// Scoreboard for the framed packet parser: tracks register writes and received bytes,
// predicts every m_ request and compares each one field by field, in order.
// Depends on fpp_pkg for the port widths, the phase encoding and reset constants.
module fpp_frame_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [fpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [7:0]                    m_frame_version,
    input  logic [7:0]                    m_frame_type,
    input  logic [15:0]                   m_frame_sequence,
    input  logic [6:0]                    m_frame_length,
    input  logic [7:0]                    m_data_byte,
    input  logic                          m_data_valid,
    input  logic                          m_last,
    output int                            fail_count,
    output int                            results_due,
    output int                            results_checked,
    output int                            frames_good,
    output int                            frames_dropped
);
    timeunit 1ns;
    timeprecision 1ps;
    import fpp_pkg::*;

    typedef struct packed {
        logic [7:0]  version;
        logic [7:0]  ftype;
        logic [15:0] seq_num;
        logic [6:0]  frame_len;
        logic [7:0]  data;
        logic        data_valid;
        logic        last_flag;
    } deframed_result_t;

    logic [7:0]       hdr_first;
    logic [7:0]       hdr_second;
    logic [7:0]       want_version;

    phase_t           parse_state;
    logic [7:0]       held_version;
    logic [7:0]       held_type;
    logic [15:0]      held_seq;
    logic [15:0]      held_len;
    logic [7:0]       payload_mem [MAX_PAYLOAD];
    logic [6:0]       pay_cnt;
    logic [15:0]      rx_crc;
    logic [15:0]      run_crc;

    deframed_result_t frame_results_due[$];
    int               mismatch_n = 0;
    int               checked_n = 0;
    int               good_n = 0;
    int               drop_n = 0;

    function automatic logic [15:0] crc16_modbus_shift(input logic [15:0] crc,
                                                       input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c = c >> 1;
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic deframed_result_t make_result(input logic [7:0] data,
                                                     input logic dv, input logic lst);
        return '{held_version, held_type, held_seq, held_len[6:0], data, dv, lst};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: checker: %s", $realtime, msg);
        mismatch_n++;
    endtask

    task automatic restart_frame();
        parse_state = ST_HEAD0;
        pay_cnt = '0;
        rx_crc = '0;
        run_crc = CRC_INIT;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        case (parse_state)
            ST_HEAD0: begin
                if (b == hdr_first) parse_state = ST_HEAD1;
            end
            ST_HEAD1: begin
                if (b == hdr_second) begin
                    parse_state = ST_VER;
                    run_crc = CRC_INIT;
                end else begin
                    parse_state = ST_HEAD0;
                end
            end
            ST_VER: begin
                held_version = b;
                run_crc = crc16_modbus_shift(run_crc, b);
                parse_state = ST_TYPE;
            end
            ST_TYPE: begin
                held_type = b;
                run_crc = crc16_modbus_shift(run_crc, b);
                parse_state = ST_SEQL;
            end
            ST_SEQL: begin
                held_seq = {8'h00, b};
                run_crc = crc16_modbus_shift(run_crc, b);
                parse_state = ST_SEQH;
            end
            ST_SEQH: begin
                held_seq[15:8] = b;
                run_crc = crc16_modbus_shift(run_crc, b);
                parse_state = ST_LENL;
            end
            ST_LENL: begin
                held_len = {8'h00, b};
                run_crc = crc16_modbus_shift(run_crc, b);
                parse_state = ST_LENH;
            end
            ST_LENH: begin
                held_len[15:8] = b;
                run_crc = crc16_modbus_shift(run_crc, b);
                if (held_version != want_version || held_len > MAX_PAYLOAD) begin
                    drop_n++;
                    restart_frame();
                end else if (held_len == 0) begin
                    parse_state = ST_CRCL;
                end else begin
                    pay_cnt = '0;
                    parse_state = ST_PAY;
                end
            end
            ST_PAY: begin
                if (pay_cnt < MAX_PAYLOAD) payload_mem[pay_cnt[5:0]] = b;
                run_crc = crc16_modbus_shift(run_crc, b);
                pay_cnt = pay_cnt + 7'd1;
                if ({9'd0, pay_cnt} >= held_len) parse_state = ST_CRCL;
            end
            ST_CRCL: begin
                rx_crc = {8'h00, b};
                parse_state = ST_CRCH;
            end
            ST_CRCH: begin
                rx_crc[15:8] = b;
                if (rx_crc == run_crc) begin
                    good_n++;
                    if (held_len == 0) begin
                        frame_results_due.push_back(make_result(8'h00, 1'b0, 1'b1));
                    end else begin
                        for (int i = 0; i < MAX_PAYLOAD; i++) begin
                            if (i < held_len) begin
                                frame_results_due.push_back(make_result(payload_mem[i], 1'b1,
                                                                        i + 1 == held_len));
                            end
                        end
                    end
                end else begin
                    drop_n++;
                end
                restart_frame();
            end
            default: begin
                restart_frame();
            end
        endcase
    endtask

    task automatic check_result();
        deframed_result_t want;
        if (frame_results_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: data %h last %b",
                                      m_data_byte, m_last));
            return;
        end
        want = frame_results_due.pop_front();
        checked_n++;
        if (m_frame_version !== want.version)
            report_mismatch($sformatf("result %0d frame_version %h, expected %h",
                                      checked_n, m_frame_version, want.version));
        if (m_frame_type !== want.ftype)
            report_mismatch($sformatf("result %0d frame_type %h, expected %h",
                                      checked_n, m_frame_type, want.ftype));
        if (m_frame_sequence !== want.seq_num)
            report_mismatch($sformatf("result %0d frame_sequence %h, expected %h",
                                      checked_n, m_frame_sequence, want.seq_num));
        if (m_frame_length !== want.frame_len)
            report_mismatch($sformatf("result %0d frame_length %0d, expected %0d",
                                      checked_n, m_frame_length, want.frame_len));
        if (m_data_byte !== want.data)
            report_mismatch($sformatf("result %0d data_byte %h, expected %h",
                                      checked_n, m_data_byte, want.data));
        if (m_data_valid !== want.data_valid)
            report_mismatch($sformatf("result %0d data_valid %b, expected %b",
                                      checked_n, m_data_valid, want.data_valid));
        if (m_last !== want.last_flag)
            report_mismatch($sformatf("result %0d last %b, expected %b",
                                      checked_n, m_last, want.last_flag));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            hdr_first = HDR_FIRST_RST;
            hdr_second = HDR_SECOND_RST;
            want_version = EXP_VERSION_RST;
            held_version = '0;
            held_type = '0;
            held_seq = '0;
            held_len = '0;
            restart_frame();
            frame_results_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HEADER_FIRST:     hdr_first = cfg_data;
                    REG_HEADER_SECOND:    hdr_second = cfg_data;
                    REG_EXPECTED_VERSION: want_version = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) parse_rx_byte(s_rx_byte);
            if (m_valid && m_ready) check_result();
        end
        fail_count      <= mismatch_n;
        results_due     <= frame_results_due.size();
        results_checked <= checked_n;
        frames_good     <= good_n;
        frames_dropped  <= drop_n;
    end

endmodule

// ===== tb/framed_packet_parser_crc16_unit_tb.sv =====
// Top of the frame parser regression: clock, reset, register writes and byte stimulus
// of well-formed, corrupted and broken frames, with a random receiver. Depends on
// fpp_pkg, the framed_packet_parser_crc16_unit RTL and fpp_frame_checker.
module framed_packet_parser_crc16_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fpp_pkg::*;

    localparam int ITEM_GOAL = 380;
    localparam int HOLD_OFF_CYCLES = 250;

    typedef enum logic [2:0] {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_VERSION,
        FR_OVERSIZE,
        FR_BROKEN
    } frame_kind_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER_FIRST;
    logic [7:0]           cfg_data = 8'h00;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = 8'h00;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_frame_version;
    logic [7:0]           m_frame_type;
    logic [15:0]          m_frame_sequence;
    logic [6:0]           m_frame_length;
    logic [7:0]           m_data_byte;
    logic                 m_data_valid;
    logic                 m_last;

    int                   fail_total;
    int                   results_due;
    int                   results_checked;
    int                   frames_good;
    int                   frames_dropped;

    logic [7:0]           hdr_first_cur = HDR_FIRST_RST;
    logic [7:0]           hdr_second_cur = HDR_SECOND_RST;
    logic [7:0]           ver_cur = EXP_VERSION_RST;
    logic [7:0]           frame_bytes[$];
    int                   bytes_sent = 0;
    logic                 quiet = 1'b0;
    int                   hold_trigger = 0;
    int                   hold_seen = 0;
    int                   hold_left = 0;

    framed_packet_parser_crc16_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_version  (m_frame_version),
        .m_frame_type     (m_frame_type),
        .m_frame_sequence (m_frame_sequence),
        .m_frame_length   (m_frame_length),
        .m_data_byte      (m_data_byte),
        .m_data_valid     (m_data_valid),
        .m_last           (m_last)
    );

    fpp_frame_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_version  (m_frame_version),
        .m_frame_type     (m_frame_type),
        .m_frame_sequence (m_frame_sequence),
        .m_frame_length   (m_frame_length),
        .m_data_byte      (m_data_byte),
        .m_data_valid     (m_data_valid),
        .m_last           (m_last),
        .fail_count       (fail_total),
        .results_due      (results_due),
        .results_checked  (results_checked),
        .frames_good      (frames_good),
        .frames_dropped   (frames_dropped)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("framed_packet_parser_crc16_unit regression: fail");
        $finish;
    end

    // The receiver runs its long hold-off whenever the stimulus bumps hold_trigger.
    always @(posedge aclk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 11);
        end
    end

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc,
                                                    input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else c = c >> 1;
        end
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        if (!quiet) begin
            while ($urandom_range(99) < 11) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame_bytes();
        foreach (frame_bytes[i]) push_byte(frame_bytes[i]);
    endtask

    task automatic build_frame(input frame_kind_t kind, input logic [7:0] ver,
                               input logic [7:0] typ, input logic [15:0] seq,
                               input logic [15:0] len16);
        logic [15:0] crc;
        logic [7:0]  b;
        frame_bytes = {hdr_first_cur, hdr_second_cur, ver, typ, seq[7:0], seq[15:8],
                       len16[7:0], len16[15:8]};
        crc = CRC_INIT;
        for (int i = 2; i < 8; i++) crc = modbus_crc_step(crc, frame_bytes[i]);
        if (kind == FR_BAD_VERSION || kind == FR_OVERSIZE) return;
        for (int i = 0; i < len16; i++) begin
            b = 8'($urandom_range(255));
            frame_bytes.push_back(b);
            crc = modbus_crc_step(crc, b);
        end
        if (kind == FR_BAD_CRC) crc = crc ^ 16'($urandom_range(65535, 1));
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    task automatic send_random_frame();
        int          pick;
        int          len;
        int          cut;
        frame_kind_t kind;
        logic [7:0]  ver;
        logic [15:0] len16;
        pick = $urandom_range(99);
        if (pick < 60) kind = FR_GOOD;
        else if (pick < 70) kind = FR_BAD_CRC;
        else if (pick < 78) kind = FR_BAD_VERSION;
        else if (pick < 86) kind = FR_OVERSIZE;
        else kind = FR_BROKEN;
        pick = $urandom_range(99);
        if (pick < 10) len = 0;
        else if (pick < 88) len = $urandom_range(8, 1);
        else if (pick < 97) len = $urandom_range(32, 9);
        else len = $urandom_range(MAX_PAYLOAD, 33);
        ver = ver_cur;
        len16 = 16'(len);
        if (kind == FR_BAD_VERSION) ver = ver_cur ^ 8'($urandom_range(255, 1));
        if (kind == FR_OVERSIZE) begin
            if ($urandom_range(1) == 0) len16 = 16'($urandom_range(255, MAX_PAYLOAD + 1));
            else len16 = {8'($urandom_range(255, 1)), 8'($urandom_range(255))};
        end
        if (kind == FR_BROKEN) begin
            case ($urandom_range(2))
                0: frame_bytes = {hdr_first_cur, hdr_first_cur, hdr_second_cur};
                1: begin
                    frame_bytes = {};
                    repeat ($urandom_range(6, 1)) frame_bytes.push_back(8'($urandom_range(255)));
                end
                default: begin
                    build_frame(FR_GOOD, ver, 8'($urandom_range(255)),
                                16'($urandom_range(65535)), len16);
                    cut = $urandom_range(frame_bytes.size() - 1, 1);
                    while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
                end
            endcase
        end else begin
            build_frame(kind, ver, 8'($urandom_range(255)), 16'($urandom_range(65535)), len16);
        end
        send_frame_bytes();
    endtask

    task automatic wait_results_drained(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [7:0] h1, input logic [7:0] h2,
                                 input logic [7:0] ver);
        wait_results_drained(8);
        write_reg(REG_HEADER_FIRST, h1);
        write_reg(REG_HEADER_SECOND, h2);
        write_reg(REG_EXPECTED_VERSION, ver);
        cfg_valid <= 1'b0;
        hdr_first_cur  = h1;
        hdr_second_cur = h2;
        ver_cur        = ver;
    endtask

    initial begin
        logic [7:0] same_hdr;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A second header byte that misses must not restart the hunt as a first byte.
        frame_bytes = {hdr_first_cur, hdr_first_cur, hdr_second_cur};
        send_frame_bytes();
        build_frame(FR_GOOD, ver_cur, 8'hFF, 16'hFFFF, 16'd0);
        send_frame_bytes();
        build_frame(FR_BAD_VERSION, 8'h00, 8'h00, 16'h0000, 16'd0);
        send_frame_bytes();
        build_frame(FR_OVERSIZE, ver_cur, 8'h5A, 16'h1234, 16'hFFFF);
        send_frame_bytes();
        build_frame(FR_BAD_CRC, ver_cur, 8'h00, 16'h0000, 16'd0);
        send_frame_bytes();

        hold_trigger <= hold_trigger + 1;
        repeat (2) begin
            build_frame(FR_GOOD, ver_cur, 8'($urandom_range(255)),
                        16'($urandom_range(65535)), 16'd6);
            send_frame_bytes();
        end

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: apply_setting(8'h00, 8'hFF, 8'hFF);
                2: apply_setting(8'hFF, 8'h00, 8'h00);
                3: apply_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)));
                4: begin
                    same_hdr = 8'($urandom_range(255));
                    apply_setting(same_hdr, same_hdr, 8'($urandom_range(255)));
                end
                default: ;
            endcase
            quiet <= (ph == 2);
            if (ph == 1) begin
                build_frame(FR_GOOD, ver_cur, 8'($urandom_range(255)),
                            16'($urandom_range(65535)), 16'(MAX_PAYLOAD));
                send_frame_bytes();
            end
            while (bytes_sent < (ph + 1) * ITEM_GOAL / 5) send_random_frame();
        end

        wait_results_drained(16);
        $display("Run covered %0d bytes over five register settings, including a long",
                 bytes_sent);
        $display("receiver hold-off: %0d frames passed, %0d dropped, %0d results checked.",
                 frames_good, frames_dropped, results_checked);
        if (fail_total == 0) begin
            $display("framed_packet_parser_crc16_unit regression: pass");
        end else begin
            $display("framed_packet_parser_crc16_unit regression: fail");
        end
        $finish;
    end

endmodule
